// ----- design/ffsa_pkg.sv -----
// Shared types and codes for the first-fit segment allocator.
// No dependencies; every other design file imports this package.
package ffsa_pkg;

  // Fixed field widths of the item and result words
  localparam int CMD_W   = 2;
  localparam int IDX_IN_W = 4;
  localparam int SIZE_W  = 16;
  localparam int ID_W    = 16;
  localparam int STAT_W  = 3;
  localparam int TOTAL_W = 20;
  localparam int CFG_W   = 5;

  // Reset value of the segment count register
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_LOADED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_EXACT     = 3'd1;
  localparam logic [STAT_W-1:0] ST_INT_FRAG  = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXT_FRAG  = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd5;
  localparam logic [STAT_W-1:0] ST_READ      = 3'd6;

  // One segment table entry
  typedef struct packed {
    logic              busy;
    logic [ID_W-1:0]   owner;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] cap;
  } entry_t;

  // One result word
  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [IDX_IN_W-1:0] seg;
    logic [TOTAL_W-1:0]  total;
    logic                busy;
    logic [ID_W-1:0]     owner;
    logic [SIZE_W-1:0]   cap;
  } result_t;

endpackage

// ----- design/ffsa_table.sv -----
// Segment table: single-port write, single-port registered read.
// Per-entry valid bits make unwritten entries read as the cleared entry.
// Depends on ffsa_pkg.
module ffsa_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output ffsa_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  ffsa_pkg::entry_t    wr_data
);
  import ffsa_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // Write the entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written entries; reset clears every mark at once
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read; hold the word when no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ----- design/ffsa_ctrl.sv -----
// Sequencer and shared compare/subtract unit of the allocator.
// Scans the segment table one entry per cycle and builds the result word.
// Depends on ffsa_pkg and ffsa_table (driven from the top level).
module ffsa_ctrl #(
  parameter int MAX_SEGMENTS = 16,
  parameter int SIZE_BITS    = 16,
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  // Item word
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ffsa_pkg::CMD_W-1:0]          cmd,
  input  logic [ffsa_pkg::IDX_IN_W-1:0]       segment_index,
  input  logic [ffsa_pkg::SIZE_W-1:0]         item_size,
  input  logic [ffsa_pkg::ID_W-1:0]           requester_id,
  input  logic [ffsa_pkg::CFG_W-1:0]          segments_in_use,
  // Table port
  output logic                                rd_en,
  output logic [IDX_W-1:0]                    rd_addr,
  input  ffsa_pkg::entry_t                    rd_data,
  output logic                                wr_en,
  output logic [IDX_W-1:0]                    wr_addr,
  output ffsa_pkg::entry_t                    wr_data,
  // Result word
  output logic                                res_valid,
  input  logic                                res_ready,
  output ffsa_pkg::result_t                   res
);
  import ffsa_pkg::*;

  localparam int KEEP = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
  localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_W'((32'd1 << KEEP) - 32'd1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LD_SUB = 3'd1;
  localparam logic [2:0] S_LD_ADD = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]          state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    ptr, ptr_next;
  logic [IDX_IN_W-1:0] seg_in, seg_in_next;
  logic [SIZE_W-1:0]   size, size_next;
  logic [ID_W-1:0]     rid, rid_next;
  logic [CNT_W-1:0]    n_lim, n_lim_next;
  logic [TOTAL_W-1:0]  total, total_next;
  logic [TOTAL_W-1:0]  part, part_next;
  result_t             res_next;

  logic [CNT_W-1:0]    n_now;
  logic [SIZE_W-1:0]   size_in;
  logic                bad_load, bad_read, hit, last;
  logic [SIZE_W-1:0]   share;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_less_size;
  result_t             fail_res;

  // Clamp the segment count to the table depth
  always_comb begin
    if (32'(segments_in_use) > 32'(MAX_SEGMENTS)) begin
      n_now = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_now = CNT_W'(segments_in_use);
    end
  end

  assign size_in  = item_size & SIZE_MASK;
  assign bad_load = 32'(segment_index) >= 32'(n_now);
  assign bad_read = 32'(segment_index) >= 32'(MAX_SEGMENTS);

  // Shared compare/subtract terms
  assign hit  = !rd_data.busy && (rd_data.cap >= size);
  assign last = (CNT_W'(ptr) + CNT_W'(1)) == n_lim;
  assign share = !rd_data.busy ? rd_data.cap :
                 (rd_data.cap >= rd_data.used) ? (rd_data.cap - rd_data.used) : '0;
  assign sum = {1'b0, part} + (TOTAL_W+1)'(size);
  assign total_less_size = (total >= TOTAL_W'(size)) ? (total - TOTAL_W'(size)) : '0;

  // Allocation failure word
  always_comb begin
    fail_res        = '0;
    fail_res.status = (TOTAL_W'(size_in) <= total && state == S_IDLE) ||
                      (TOTAL_W'(size) <= total && state != S_IDLE) ?
                      ST_EXT_FRAG : ST_TOO_LARGE;
    fail_res.total  = total;
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  // Sequencer
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    ptr_next    = ptr;
    seg_in_next = seg_in;
    size_next   = size;
    rid_next    = rid;
    n_lim_next  = n_lim;
    total_next  = total;
    part_next   = part;
    res_next    = res;
    rd_en       = 1'b0;
    rd_addr     = ptr;
    wr_en       = 1'b0;
    wr_addr     = idx;
    wr_data     = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx_next    = IDX_W'(segment_index);
          seg_in_next = segment_index;
          size_next   = size_in;
          rid_next    = requester_id;
          n_lim_next  = n_now;
          ptr_next    = '0;
          res_next    = '0;
          res_next.status = ST_BAD_INDEX;
          res_next.total  = total;
          state_next  = S_EMIT;
          case (cmd)
            CMD_LOAD: begin
              if (!bad_load) begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(segment_index);
                state_next = S_LD_SUB;
              end
            end
            CMD_ALLOC: begin
              if (n_now == '0) begin
                res_next = fail_res;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_SCAN;
              end
            end
            CMD_READ: begin
              if (!bad_read) begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(segment_index);
                state_next = S_RD;
              end
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end
      // Drop the old share of the segment from the total
      S_LD_SUB: begin
        part_next  = (total >= TOTAL_W'(share)) ? (total - TOTAL_W'(share)) : '0;
        state_next = S_LD_ADD;
      end
      // Add the new size, saturating, and write the entry back free with the new size as capacity
      S_LD_ADD: begin
        total_next      = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        wr_en           = 1'b1;
        wr_addr         = idx;
        wr_data.cap     = size;
        res_next        = '0;
        res_next.status = ST_LOADED;
        res_next.seg    = seg_in;
        res_next.total  = total_next;
        res_next.cap    = size;
        state_next      = S_EMIT;
      end
      // Test one entry per cycle, first fit wins
      S_SCAN: begin
        if (hit) begin
          wr_en           = 1'b1;
          wr_addr         = ptr;
          wr_data.busy    = 1'b1;
          wr_data.owner   = rid;
          wr_data.used    = size;
          wr_data.cap     = rd_data.cap;
          total_next      = total_less_size;
          res_next.status = (rd_data.cap == size) ? ST_EXACT : ST_INT_FRAG;
          res_next.seg    = IDX_IN_W'(ptr);
          res_next.total  = total_less_size;
          res_next.busy   = 1'b1;
          res_next.owner  = rid;
          res_next.cap    = rd_data.cap;
          state_next      = S_EMIT;
        end else if (last) begin
          res_next   = fail_res;
          state_next = S_EMIT;
        end else begin
          ptr_next   = ptr + IDX_W'(1);
          rd_en      = 1'b1;
          rd_addr    = ptr + IDX_W'(1);
        end
      end
      S_RD: begin
        res_next.status = ST_READ;
        res_next.seg    = seg_in;
        res_next.total  = total;
        res_next.busy   = rd_data.busy;
        res_next.owner  = rd_data.owner;
        res_next.cap    = rd_data.cap;
        state_next      = S_EMIT;
      end
      // Hold the word until the output register takes it
      S_EMIT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
    end else begin
      state <= state_next;
      total <= total_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    ptr    <= ptr_next;
    seg_in <= seg_in_next;
    size   <= size_next;
    rid    <= rid_next;
    n_lim  <= n_lim_next;
    part   <= part_next;
    res    <= res_next;
  end

endmodule

// ----- design/first_fit_segment_allocator_core.sv -----
// First-fit segment allocator. A bad index, unknown command or an allocate with a
// segment count of 0 gives its result word without a table read; a read or load reads the
// entry first, and an allocate scans the entries one table read per cycle, up to the
// segment count. The next item is taken the cycle after the result word leaves the
// sequencer; the output register lets it wait. Reset (rst, synchronous) frees every
// segment, clears the available total and sets the segment count to 16.
module first_fit_segment_allocator_core #(
  parameter int MAX_SEGMENTS = 16,
  parameter int SIZE_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ffsa_pkg::CFG_W-1:0]        cfg_data,
  // Item channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ffsa_pkg::CMD_W-1:0]        cmd,
  input  logic [ffsa_pkg::IDX_IN_W-1:0]     segment_index,
  input  logic [ffsa_pkg::SIZE_W-1:0]       item_size,
  input  logic [ffsa_pkg::ID_W-1:0]         requester_id,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ffsa_pkg::STAT_W-1:0]       status,
  output logic [ffsa_pkg::IDX_IN_W-1:0]     chosen_segment,
  output logic [ffsa_pkg::TOTAL_W-1:0]      available_total,
  output logic                              segment_busy,
  output logic [ffsa_pkg::ID_W-1:0]         segment_owner,
  output logic [ffsa_pkg::SIZE_W-1:0]       segment_capacity
);
  import ffsa_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = IDX_W + 1;

  logic [CFG_W-1:0] segments_in_use;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           rd_data, wr_data;
  logic             res_valid, res_ready;
  result_t          res, out_q;

  // Segment count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      segments_in_use <= CFG_RESET;
    end else if (cfg_valid) begin
      segments_in_use <= cfg_data;
    end
  end

  ffsa_table #(
    .DEPTH (MAX_SEGMENTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffsa_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SIZE_BITS    (SIZE_BITS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .segment_index   (segment_index),
    .item_size       (item_size),
    .requester_id    (requester_id),
    .segments_in_use (segments_in_use),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // Output register: take a word when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign status           = out_q.status;
  assign chosen_segment   = out_q.seg;
  assign available_total  = out_q.total;
  assign segment_busy     = out_q.busy;
  assign segment_owner    = out_q.owner;
  assign segment_capacity = out_q.cap;

endmodule
